### design/assert_macros.svh
// assertion macros used by the top level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define CSPG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CSPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/cspg_pkg.sv
// types, codes and reset constants of the counted step pulse generator
`timescale 1ns / 1ps
`default_nettype none

package cspg_pkg;

   localparam int TICKS_PER_SECOND_DEF = 10;

   localparam logic [15:0] COMPARE_PERIOD_RESET     = 16'd100;
   localparam logic [14:0] STEPS_PER_ROTATION_RESET = 15'd200;
   localparam logic        HALF_STEP_MODE_RESET     = 1'b1;
   localparam logic        ALWAYS_ENABLE_RESET      = 1'b0;
   localparam logic [15:0] HALL_TIMEOUT_RESET       = 16'd60;
   localparam logic [15:0] CONTINUOUS_CODE_RESET    = 16'hFFFF;
   localparam logic [15:0] STEP_COUNT_RESET         = 16'd200;

   typedef enum logic [1:0] {
      ACT_TIMER_TICK = 2'd0,
      ACT_START      = 2'd1,
      ACT_STOP       = 2'd2,
      ACT_SUPERVISE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_COMPARE_PERIOD     = 3'd0,
      REG_STEPS_PER_ROTATION = 3'd1,
      REG_HALF_STEP_MODE     = 3'd2,
      REG_ALWAYS_ENABLE      = 3'd3,
      REG_HALL_TIMEOUT       = 3'd4,
      REG_CONTINUOUS_CODE    = 3'd5
   } csr_index_type;

   typedef struct packed {
      action_type  action;
      logic [15:0] rotations_to_run;
      logic        hall_level;
   } req_word_type;

   typedef struct packed {
      logic        step_strobe;
      logic        running;
      logic        driver_enable;
      logic        relay_on;
      logic        hall_pulse_toggle;
      logic [15:0] rotations_left;
      logic        finished;
   } rsp_word_type;

   typedef struct packed {
      csr_index_type index;
      logic [15:0]   wdata;
   } csr_word_type;

   typedef struct packed {
      logic        relay_on;
      logic        hall_pulse_toggle;
   } wdog_status_type;

endpackage

`default_nettype wire

### design/cspg_chan_if.sv
// valid/ready channel carrying one word
`timescale 1ns / 1ps
`default_nettype none

interface cspg_chan_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/cspg_watchdog.sv
// hall edge watchdog driving the fault relay
`timescale 1ns / 1ps
`default_nettype none

module cspg_watchdog #(
   parameter int TICKS_PER_SECOND = cspg_pkg::TICKS_PER_SECOND_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fire,
   input  wire logic                       running,
   input  wire logic                       hall_level,
   input  wire logic [15:0]                timeout,
   output cspg_pkg::wdog_status_type       status_in
);

   localparam int DIV_W = $clog2(TICKS_PER_SECOND + 1);

   logic             hall_prev_ff, hall_prev_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [15:0]      count_ff, count_in;
   logic             toggle_ff, toggle_in;
   logic             relay_ff, relay_in;

   logic             rise;
   logic [DIV_W-1:0] div_base, div_next;
   logic [15:0]      count_base;

   always_comb begin
      hall_prev_in = hall_prev_ff;
      div_in       = div_ff;
      count_in     = count_ff;
      toggle_in    = toggle_ff;
      relay_in     = relay_ff;
      rise         = hall_level & ~hall_prev_ff;
      div_base     = rise ? '0 : div_ff;
      count_base   = rise ? timeout : count_ff;
      div_next     = div_base + DIV_W'(1);
      if (fire) begin
         if (!running) begin
            count_in = timeout;
            div_in   = '0;
         end else begin
            if (rise) begin
               toggle_in = ~toggle_ff;
               relay_in  = 1'b1;
            end
            hall_prev_in = hall_level;
            count_in     = count_base;
            if (div_next == DIV_W'(TICKS_PER_SECOND)) begin
               div_in = '0;
               if (count_base != 16'd0) begin
                  count_in = count_base - 16'd1;
               end else begin
                  relay_in = 1'b0;
               end
            end else begin
               div_in = div_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hall_prev_ff <= 1'b0;
         div_ff       <= '0;
         count_ff     <= cspg_pkg::HALL_TIMEOUT_RESET;
         toggle_ff    <= 1'b0;
         relay_ff     <= 1'b1;
      end else begin
         hall_prev_ff <= hall_prev_in;
         div_ff       <= div_in;
         count_ff     <= count_in;
         toggle_ff    <= toggle_in;
         relay_ff     <= relay_in;
      end
   end

   assign status_in.relay_on          = relay_in;
   assign status_in.hall_pulse_toggle = toggle_in;

endmodule

`default_nettype wire

### design/counted_step_pulse_generator_unit.sv
// top level of the counted step pulse generator
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Takes one request word per clock cycle and returns one response word for each,
// in the cycle after it is accepted, from a result register. Every action (timer
// tick, start, stop, 100 ms supervision tick) is settled in the cycle of
// acceptance, so the rate is one word per cycle; the request side stalls only
// while the result register is full and the response side does not take it.
// Register writes on the csr channel are always accepted and take effect on the
// next request word.
module counted_step_pulse_generator_unit #(
   parameter int TICKS_PER_SECOND = cspg_pkg::TICKS_PER_SECOND_DEF
) (
   input wire logic clock,
   input wire logic reset,
   cspg_chan_if.sink   req_chan,
   cspg_chan_if.source rsp_chan,
   cspg_chan_if.sink   csr_chan
);

   // configuration registers
   logic [15:0] compare_period_ff;
   logic [14:0] steps_per_rotation_ff;
   logic        half_step_mode_ff;
   logic        always_enable_ff;
   logic [15:0] hall_timeout_ff;
   logic [15:0] continuous_code_ff;

   // motor state
   logic [15:0] tick_ff, tick_in;
   logic [15:0] step_ff, step_in;
   logic [15:0] rot_ff, rot_in;
   logic        run_ff, run_in;
   logic        enable_ff, enable_in;

   logic                   rsp_valid_ff;
   cspg_pkg::rsp_word_type rsp_word_ff;

   cspg_pkg::req_word_type    req_word;
   cspg_pkg::wdog_status_type wdog_status;
   logic        req_accept;
   logic        csr_accept;
   logic        pulse;
   logic        finished;
   logic [15:0] step_reload;

   assign req_word   = req_chan.data;
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign req_accept = req_chan.valid & req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_accept = csr_chan.valid;

   assign step_reload = half_step_mode_ff ? {steps_per_rotation_ff, 1'b0}
                                          : {1'b0, steps_per_rotation_ff};

   always_comb begin
      tick_in   = tick_ff;
      step_in   = step_ff;
      rot_in    = rot_ff;
      run_in    = run_ff;
      enable_in = enable_ff;
      pulse     = 1'b0;
      finished  = 1'b0;
      case (req_word.action)
         cspg_pkg::ACT_TIMER_TICK: begin
            if (run_ff) begin
               if (tick_ff >= compare_period_ff) begin
                  tick_in = 16'd0;
                  if (rot_ff != 16'd0) begin
                     if (rot_ff != continuous_code_ff && step_ff == 16'd0) begin
                        rot_in  = rot_ff - 16'd1;
                        step_in = step_reload;
                     end else begin
                        pulse   = 1'b1;
                        step_in = step_ff - 16'd1;
                     end
                  end else begin
                     step_in   = 16'd0;
                     run_in    = 1'b0;
                     enable_in = enable_ff & always_enable_ff;
                     finished  = 1'b1;
                  end
               end else begin
                  tick_in = tick_ff + 16'd1;
               end
            end
         end
         cspg_pkg::ACT_START: begin
            enable_in = 1'b1;
            step_in   = step_reload;
            rot_in    = req_word.rotations_to_run;
            tick_in   = 16'd0;
            run_in    = 1'b1;
         end
         cspg_pkg::ACT_STOP: begin
            finished  = run_ff;
            step_in   = 16'd0;
            run_in    = 1'b0;
            enable_in = enable_ff & always_enable_ff;
         end
         default: begin
         end
      endcase
   end

   cspg_watchdog #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_watchdog (
      .clock      (clock),
      .reset      (reset),
      .fire       (req_accept && req_word.action == cspg_pkg::ACT_SUPERVISE),
      .running    (run_ff),
      .hall_level (req_word.hall_level),
      .timeout    (hall_timeout_ff),
      .status_in  (wdog_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_period_ff     <= cspg_pkg::COMPARE_PERIOD_RESET;
         steps_per_rotation_ff <= cspg_pkg::STEPS_PER_ROTATION_RESET;
         half_step_mode_ff     <= cspg_pkg::HALF_STEP_MODE_RESET;
         always_enable_ff      <= cspg_pkg::ALWAYS_ENABLE_RESET;
         hall_timeout_ff       <= cspg_pkg::HALL_TIMEOUT_RESET;
         continuous_code_ff    <= cspg_pkg::CONTINUOUS_CODE_RESET;
      end else if (csr_accept) begin
         case (csr_chan.data.index)
            cspg_pkg::REG_COMPARE_PERIOD:     compare_period_ff <= csr_chan.data.wdata;
            cspg_pkg::REG_STEPS_PER_ROTATION: steps_per_rotation_ff <= csr_chan.data.wdata[14:0];
            cspg_pkg::REG_HALF_STEP_MODE:     half_step_mode_ff <= csr_chan.data.wdata[0];
            cspg_pkg::REG_ALWAYS_ENABLE:      always_enable_ff <= csr_chan.data.wdata[0];
            cspg_pkg::REG_HALL_TIMEOUT:       hall_timeout_ff <= csr_chan.data.wdata;
            cspg_pkg::REG_CONTINUOUS_CODE:    continuous_code_ff <= csr_chan.data.wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= 16'd0;
         step_ff      <= cspg_pkg::STEP_COUNT_RESET;
         rot_ff       <= 16'd0;
         run_ff       <= 1'b0;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            tick_ff      <= tick_in;
            step_ff      <= step_in;
            rot_ff       <= rot_in;
            run_ff       <= run_in;
            enable_ff    <= enable_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff.step_strobe       <= pulse;
         rsp_word_ff.running           <= run_in;
         rsp_word_ff.driver_enable     <= enable_in;
         rsp_word_ff.relay_on          <= wdog_status.relay_on;
         rsp_word_ff.hall_pulse_toggle <= wdog_status.hall_pulse_toggle;
         rsp_word_ff.rotations_left    <= rot_in;
         rsp_word_ff.finished          <= finished;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

   `CSPG_ASSERT_NEXT(a_accept_gives_word, clock, reset, req_accept, rsp_chan.valid, "accepted word gave no response")
   `CSPG_ASSERT_NEXT(a_start_runs, clock, reset, req_accept && req_word.action == cspg_pkg::ACT_START, rsp_chan.data.running && rsp_chan.data.driver_enable, "start did not run the motor")
   `CSPG_ASSERT_SAME(a_pulse_while_running, clock, reset, rsp_chan.valid && rsp_chan.data.step_strobe, rsp_chan.data.running && !rsp_chan.data.finished, "step pulse outside run state")

endmodule

`default_nettype wire

### bench/counted_step_pulse_generator_unit_tb.sv
// self-checking bench for the counted step pulse generator: random and directed words, own model
`timescale 1ns / 1ps

module counted_step_pulse_generator_unit_tb;

   localparam int TICKS_PER_SEC = cspg_pkg::TICKS_PER_SECOND_DEF;
   localparam int PHASES = 9;
   localparam int WORDS_PER_PHASE = 132;
   localparam int LONG_HOLD = 60;
   localparam int IDLE_LIMIT = 1000;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   cspg_pkg::req_word_type req_data = '0;
   logic                   rsp_ready = 1'b0;
   logic                   csr_valid = 1'b0;
   cspg_pkg::csr_word_type csr_data = '0;

   cspg_chan_if #(.word_type(cspg_pkg::req_word_type)) req_chan ();
   cspg_chan_if #(.word_type(cspg_pkg::rsp_word_type)) rsp_chan ();
   cspg_chan_if #(.word_type(cspg_pkg::csr_word_type)) csr_chan ();

   assign req_chan.valid = req_valid;
   assign req_chan.data  = req_data;
   assign rsp_chan.ready = rsp_ready;
   assign csr_chan.valid = csr_valid;
   assign csr_chan.data  = csr_data;

   counted_step_pulse_generator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // register copies
   logic [15:0] cfg_period  = cspg_pkg::COMPARE_PERIOD_RESET;
   logic [14:0] cfg_steps   = cspg_pkg::STEPS_PER_ROTATION_RESET;
   logic        cfg_half    = cspg_pkg::HALF_STEP_MODE_RESET;
   logic        cfg_always  = cspg_pkg::ALWAYS_ENABLE_RESET;
   logic [15:0] cfg_timeout = cspg_pkg::HALL_TIMEOUT_RESET;
   logic [15:0] cfg_cont    = cspg_pkg::CONTINUOUS_CODE_RESET;

   // motor and watchdog state
   logic [15:0] tick_cnt  = '0;
   logic [15:0] step_cnt  = cspg_pkg::STEP_COUNT_RESET;
   logic [15:0] rot_cnt   = '0;
   logic        run_f     = 1'b0;
   logic        en_f      = cspg_pkg::ALWAYS_ENABLE_RESET;
   logic        relay_f   = 1'b1;
   logic        hall_prev = 1'b0;
   logic [3:0]  tenth     = '0;
   logic [15:0] hall_cd   = cspg_pkg::HALL_TIMEOUT_RESET;
   logic        toggle_f  = 1'b0;

   cspg_pkg::req_word_type pending_words[$];
   cspg_pkg::rsp_word_type expected_words[$];

   int unsigned words_sent = 0;
   int unsigned words_seen = 0;
   int unsigned mismatches = 0;
   int unsigned pulses_due = 0;
   int unsigned stops_due  = 0;
   int unsigned relay_drops = 0;
   int unsigned settings_run = 0;
   int unsigned req_wait = 0;
   int unsigned rsp_wait = 0;
   logic        hall_now = 1'b0;

   function automatic logic [15:0] step_reload();
      if (cfg_half)
         return {cfg_steps, 1'b0};
      return {1'b0, cfg_steps};
   endfunction

   task automatic halt_motor();
      step_cnt = '0;
      run_f = 1'b0;
      if (!cfg_always)
         en_f = 1'b0;
   endtask

   task automatic compute_step(input cspg_pkg::req_word_type w,
                               output cspg_pkg::rsp_word_type r);
      logic pulse;
      logic done;
      logic relay_was;
      pulse = 1'b0;
      done = 1'b0;
      relay_was = relay_f;
      case (w.action)
         cspg_pkg::ACT_TIMER_TICK: begin
            if (run_f) begin
               if (tick_cnt >= cfg_period) begin
                  tick_cnt = '0;
                  if (rot_cnt != 16'd0) begin
                     if (rot_cnt != cfg_cont && step_cnt == 16'd0) begin
                        rot_cnt = rot_cnt - 16'd1;
                        step_cnt = step_reload();
                     end else begin
                        pulse = 1'b1;
                        step_cnt = step_cnt - 16'd1;
                     end
                  end else begin
                     halt_motor();
                     done = 1'b1;
                  end
               end else begin
                  tick_cnt = tick_cnt + 16'd1;
               end
            end
         end
         cspg_pkg::ACT_START: begin
            en_f = 1'b1;
            step_cnt = step_reload();
            rot_cnt = w.rotations_to_run;
            tick_cnt = '0;
            run_f = 1'b1;
         end
         cspg_pkg::ACT_STOP: begin
            done = run_f;
            halt_motor();
         end
         default: begin
            if (!run_f) begin
               hall_cd = cfg_timeout;
               tenth = '0;
            end else begin
               if (w.hall_level && !hall_prev) begin
                  toggle_f = ~toggle_f;
                  relay_f = 1'b1;
                  hall_cd = cfg_timeout;
                  tenth = '0;
               end
               hall_prev = w.hall_level;
               tenth = tenth + 4'd1;
               if (tenth >= TICKS_PER_SEC) begin
                  tenth = '0;
                  if (hall_cd != 16'd0)
                     hall_cd = hall_cd - 16'd1;
                  else
                     relay_f = 1'b0;
               end
            end
         end
      endcase
      if (pulse)
         pulses_due++;
      if (done)
         stops_due++;
      if (relay_was && !relay_f)
         relay_drops++;
      r.step_strobe       = pulse;
      r.running           = run_f;
      r.driver_enable     = en_f;
      r.relay_on          = relay_f;
      r.hall_pulse_toggle = toggle_f;
      r.rotations_left    = rot_cnt;
      r.finished          = done;
   endtask

   function automatic int unsigned draw_wait(input int unsigned count);
      if (((count / 64) % 4) == 3)
         return 0;
      return $urandom_range(0, 7);
   endfunction

   // request driver
   always @(posedge clock) begin : drive_req
      logic                   next_valid;
      cspg_pkg::req_word_type next_data;
      cspg_pkg::rsp_word_type want;
      if (reset) begin
         req_valid <= 1'b0;
         req_wait = 0;
      end else begin
         next_valid = req_valid;
         next_data = req_data;
         if (req_valid && req_chan.ready) begin
            compute_step(req_data, want);
            expected_words.push_back(want);
            words_sent++;
            next_valid = 1'b0;
            req_wait = draw_wait(words_sent);
         end
         if (!next_valid) begin
            if (req_wait != 0) begin
               req_wait--;
            end else if (pending_words.size() != 0) begin
               next_data = pending_words.pop_front();
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
         req_data <= next_data;
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : watch_rsp
      cspg_pkg::rsp_word_type want;
      cspg_pkg::rsp_word_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_ready && rsp_chan.valid) begin
            got = rsp_chan.data;
            words_seen++;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response word %0d: %h", words_seen, got);
            end else begin
               want = expected_words.pop_front();
               if (got.step_strobe !== want.step_strobe || got.running !== want.running ||
                   got.driver_enable !== want.driver_enable ||
                   got.relay_on !== want.relay_on ||
                   got.hall_pulse_toggle !== want.hall_pulse_toggle ||
                   got.rotations_left !== want.rotations_left ||
                   got.finished !== want.finished) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("word %0d expected pulse=%b run=%b en=%b relay=%b tog=%b rot=%0d fin=%b",
                              words_seen, want.step_strobe, want.running, want.driver_enable,
                              want.relay_on, want.hall_pulse_toggle, want.rotations_left,
                              want.finished);
                     $display("word %0d actual   pulse=%b run=%b en=%b relay=%b tog=%b rot=%0d fin=%b",
                              words_seen, got.step_strobe, got.running, got.driver_enable,
                              got.relay_on, got.hall_pulse_toggle, got.rotations_left,
                              got.finished);
                  end
               end
            end
            rsp_wait = draw_wait(words_seen);
            // long hold so that the result register fills and the request side stalls
            if (words_seen == 333 || words_seen == 777)
               rsp_wait = LONG_HOLD;
         end
         if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready) || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout after %0d quiet cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   task automatic queue_word(input cspg_pkg::action_type act, input logic [15:0] rot,
                             input logic hall);
      cspg_pkg::req_word_type w;
      w.action = act;
      w.rotations_to_run = rot;
      w.hall_level = hall;
      pending_words.push_back(w);
   endtask

   task automatic write_reg(input cspg_pkg::csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_data <= '{index: idx, wdata: value};
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
      csr_valid <= 1'b0;
      case (idx)
         cspg_pkg::REG_COMPARE_PERIOD:     cfg_period = value;
         cspg_pkg::REG_STEPS_PER_ROTATION: cfg_steps = value[14:0];
         cspg_pkg::REG_HALF_STEP_MODE:     cfg_half = value[0];
         cspg_pkg::REG_ALWAYS_ENABLE:      cfg_always = value[0];
         cspg_pkg::REG_HALL_TIMEOUT:       cfg_timeout = value;
         cspg_pkg::REG_CONTINUOUS_CODE:    cfg_cont = value;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [15:0] period, input logic [15:0] steps,
                            input logic half, input logic always_on,
                            input logic [15:0] timeout, input logic [15:0] cont);
      write_reg(cspg_pkg::REG_COMPARE_PERIOD, period);
      write_reg(cspg_pkg::REG_STEPS_PER_ROTATION, steps);
      write_reg(cspg_pkg::REG_HALF_STEP_MODE, {15'd0, half});
      write_reg(cspg_pkg::REG_ALWAYS_ENABLE, {15'd0, always_on});
      write_reg(cspg_pkg::REG_HALL_TIMEOUT, timeout);
      write_reg(cspg_pkg::REG_CONTINUOUS_CODE, cont);
      settings_run++;
   endtask

   // wait until every word is out and every response has come back
   task automatic drain();
      while (pending_words.size() != 0 || expected_words.size() != 0 || req_valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_rotations();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 50)
         return 16'($urandom_range(0, 3));
      if (p < 65)
         return cfg_cont;
      if (p < 85)
         return 16'($urandom);
      if (p < 93)
         return 16'h0000;
      return 16'hFFFF;
   endfunction

   function automatic cspg_pkg::req_word_type random_word();
      cspg_pkg::req_word_type w;
      int unsigned p;
      p = $urandom_range(0, 99);
      w.rotations_to_run = 16'($urandom);
      if ($urandom_range(0, 7) == 0)
         hall_now = ~hall_now;
      w.hall_level = ($urandom_range(0, 19) == 0) ? ~hall_now : hall_now;
      if (p < 58) begin
         w.action = cspg_pkg::ACT_TIMER_TICK;
      end else if (p < 84) begin
         w.action = cspg_pkg::ACT_SUPERVISE;
      end else if (p < 95) begin
         w.action = cspg_pkg::ACT_START;
         w.rotations_to_run = pick_rotations();
      end else begin
         w.action = cspg_pkg::ACT_STOP;
      end
      return w;
   endfunction

   initial begin : run_plan
      logic [15:0] cont;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values: idle actions, start, hall edge, stop while running
      queue_word(cspg_pkg::ACT_TIMER_TICK, 16'hFFFF, 1'b1);
      queue_word(cspg_pkg::ACT_STOP, 16'h0000, 1'b0);
      queue_word(cspg_pkg::ACT_START, 16'hFFFF, 1'b0);
      queue_word(cspg_pkg::ACT_SUPERVISE, 16'h0000, 1'b1);
      queue_word(cspg_pkg::ACT_STOP, 16'hFFFF, 1'b1);
      drain();

      write_all(16'd0, 16'd1, 1'b0, 1'b1, 16'd0, 16'd5);
      // continuous run wraps the step counter
      queue_word(cspg_pkg::ACT_START, 16'd5, 1'b0);
      queue_word(cspg_pkg::ACT_TIMER_TICK, 16'd0, 1'b0);
      queue_word(cspg_pkg::ACT_TIMER_TICK, 16'd0, 1'b0);
      queue_word(cspg_pkg::ACT_TIMER_TICK, 16'd0, 1'b0);
      // hall edge then silence until the relay drops
      queue_word(cspg_pkg::ACT_SUPERVISE, 16'd0, 1'b1);
      repeat (9) queue_word(cspg_pkg::ACT_SUPERVISE, 16'd0, 1'b0);
      // zero rotations stop at the first event, enable held
      queue_word(cspg_pkg::ACT_START, 16'd0, 1'b0);
      queue_word(cspg_pkg::ACT_TIMER_TICK, 16'd0, 1'b0);
      // one rotation: pulse, reload, stop
      queue_word(cspg_pkg::ACT_START, 16'd1, 1'b1);
      queue_word(cspg_pkg::ACT_TIMER_TICK, 16'd0, 1'b0);
      queue_word(cspg_pkg::ACT_TIMER_TICK, 16'd0, 1'b0);
      queue_word(cspg_pkg::ACT_TIMER_TICK, 16'd0, 1'b0);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: write_all(16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0);
            1: write_all(16'hFFFF, 16'h7FFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
            2: write_all(16'd0, 16'h7FFF, 1'b1, 1'b0, 16'd1, 16'd0);
            default: begin
               case ($urandom_range(0, 2))
                  0: cont = 16'($urandom_range(0, 3));
                  1: cont = 16'hFFFF;
                  default: cont = 16'($urandom);
               endcase
               write_all(($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 20))
                                                      : 16'($urandom_range(0, 3)),
                         16'($urandom_range(0, 5)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 16'($urandom_range(0, 3)), cont);
            end
         endcase
         repeat (WORDS_PER_PHASE) pending_words.push_back(random_word());
         drain();
      end

      repeat (10) @(posedge clock);
      $display("ran %0d request words, %0d responses, %0d register settings",
               words_sent, words_seen, settings_run);
      $display("predicted %0d step pulses, %0d stops, %0d relay drops; %0d mismatches",
               pulses_due, stops_due, relay_drops, mismatches);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
